// File: rtl/crcsk_pkg.sv
// ----------------------------------------------------------------------------
// crcsk_pkg
// shared types, codes and the crc byte step of the record crc checker
// ----------------------------------------------------------------------------
`default_nettype none

package crcsk_pkg;

  localparam int MAX_SKIP_AREAS = 8;
  localparam int OFFSET_BITS    = 16;
  localparam int QUEUE_DEPTH    = 2;

  localparam int FIELD_W     = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_START = 32'd987654;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CHECK_MODE     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_PRESENT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESULT_OFFSET  = 2'd2;

  typedef enum logic [1:0] {
    KIND_CRC     = 2'd0,
    KIND_CAPTURE = 2'd1,
    KIND_SKIP    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [1:0] lane;
    logic       last;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/crcsk_front.sv
// ----------------------------------------------------------------------------
// crcsk_front
// accepts items, keeps the skip list and byte position, classifies bytes
// ----------------------------------------------------------------------------
`default_nettype none

module crcsk_front #(
  parameter int MAX_SKIP_AREAS = crcsk_pkg::MAX_SKIP_AREAS,
  parameter int OFFSET_BITS    = crcsk_pkg::OFFSET_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_stall,
  input  wire logic [1:0]                    func,
  input  wire logic [7:0]                    data_byte,
  input  wire logic [crcsk_pkg::FIELD_W-1:0] area_offset,
  input  wire logic [crcsk_pkg::FIELD_W-1:0] area_size,
  input  wire logic                          last_byte,
  input  wire logic                          result_present,
  input  wire logic [OFFSET_BITS-1:0]        result_offset,
  output logic                               push,
  output crcsk_pkg::entry_t                  push_entry,
  input  wire logic                          queue_full
);

  localparam int AW = OFFSET_BITS;
  localparam int FW = crcsk_pkg::FIELD_W;
  localparam int CW = $clog2(MAX_SKIP_AREAS + 1);
  localparam int IW = (MAX_SKIP_AREAS > 1) ? $clog2(MAX_SKIP_AREAS) : 1;
  localparam logic [AW-1:0] POS_MAX = {AW{1'b1}};

  logic [AW-1:0] pos;
  logic [AW-1:0] pos_next;
  logic [CW-1:0] skip_count;
  logic [AW-1:0] skip_off [MAX_SKIP_AREAS];
  logic [AW:0]   skip_end [MAX_SKIP_AREAS];

  logic              accept;
  logic [FW+AW-1:0]  aoff_ext;
  logic [FW+AW-1:0]  asize_ext;
  logic [AW-1:0]     aoff;
  logic [AW-1:0]     asize;
  logic [AW:0]       word_end;
  logic [AW-1:0]     word_diff;
  logic              in_word;
  logic              in_skip;

  assign item_stall = queue_full;
  assign accept     = item_valid && !item_stall;

  assign aoff_ext  = {{AW{1'b0}}, area_offset};
  assign asize_ext = {{AW{1'b0}}, area_size};
  assign aoff      = aoff_ext[AW-1:0];
  assign asize     = asize_ext[AW-1:0];

  assign word_end  = {1'b0, result_offset} + (AW+1)'(4);
  assign word_diff = pos - result_offset;
  assign in_word   = result_present && (pos >= result_offset) && ({1'b0, pos} < word_end);

  always_comb begin
    in_skip = 1'b0;
    for (int i = 0; i < MAX_SKIP_AREAS; i++) begin
      if ((CW'(i) < skip_count) && (pos >= skip_off[i]) && ({1'b0, pos} < skip_end[i])) begin
        in_skip = 1'b1;
      end
    end
  end

  always_comb begin
    if (last_byte) begin
      pos_next = '0;
    end else if (pos == POS_MAX) begin
      pos_next = pos;
    end else begin
      pos_next = pos + AW'(1);
    end
  end

  assign push            = accept && (func == crcsk_pkg::FUNC_BYTE);
  assign push_entry.data = data_byte;
  assign push_entry.lane = word_diff[1:0];
  assign push_entry.last = last_byte;

  always_comb begin
    if (in_word) begin
      push_entry.kind = crcsk_pkg::KIND_CAPTURE;
    end else if (in_skip) begin
      push_entry.kind = crcsk_pkg::KIND_SKIP;
    end else begin
      push_entry.kind = crcsk_pkg::KIND_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      skip_count <= '0;
    end else if (accept) begin
      case (func)
        crcsk_pkg::FUNC_BYTE: begin
          pos <= pos_next;
        end
        crcsk_pkg::FUNC_ADD: begin
          if (skip_count < CW'(MAX_SKIP_AREAS)) begin
            skip_count <= skip_count + CW'(1);
          end
        end
        crcsk_pkg::FUNC_CLEAR: begin
          skip_count <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // skip entries hold no reset, only counted entries are read
  always_ff @(posedge clk) begin
    if (accept && (func == crcsk_pkg::FUNC_ADD) && (skip_count < CW'(MAX_SKIP_AREAS))) begin
      skip_off[skip_count[IW-1:0]] <= aoff;
      skip_end[skip_count[IW-1:0]] <= {1'b0, aoff} + {1'b0, asize};
    end
  end

endmodule

`default_nettype wire

// File: rtl/crcsk_queue.sv
// ----------------------------------------------------------------------------
// crcsk_queue
// short fifo of classified bytes between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module crcsk_queue #(
  parameter int DEPTH = crcsk_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  crcsk_pkg::entry_t      push_entry,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output crcsk_pkg::entry_t      head_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  crcsk_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full       = (count == NW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + NW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// File: rtl/crcsk_back.sv
// ----------------------------------------------------------------------------
// crcsk_back
// runs the crc step, captures the result word and registers the result beat
// ----------------------------------------------------------------------------
`default_nettype none

module crcsk_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          check_mode,
  input  wire logic          head_valid,
  input  crcsk_pkg::entry_t  head_entry,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [31:0]        crc_value,
  output logic               mismatch
);

  logic [31:0] crc;
  logic [31:0] captured;
  logic [31:0] crc_next;
  logic [31:0] captured_next;

  assign pop = head_valid && (!head_entry.last || !result_valid || !result_stall);

  always_comb begin
    if (head_entry.kind == crcsk_pkg::KIND_CRC) begin
      crc_next = crcsk_pkg::crc_byte(crc, head_entry.data);
    end else begin
      crc_next = crc;
    end
  end

  always_comb begin
    captured_next = captured;
    if (head_entry.kind == crcsk_pkg::KIND_CAPTURE) begin
      case (head_entry.lane)
        2'd0:    captured_next[7:0]   = head_entry.data;
        2'd1:    captured_next[15:8]  = head_entry.data;
        2'd2:    captured_next[23:16] = head_entry.data;
        default: captured_next[31:24] = head_entry.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= crcsk_pkg::CRC_START;
      captured <= '0;
    end else if (pop) begin
      if (head_entry.last) begin
        crc      <= crcsk_pkg::CRC_START;
        captured <= '0;
      end else begin
        crc      <= crc_next;
        captured <= captured_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && head_entry.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_entry.last) begin
      crc_value <= crc_next;
      mismatch  <= check_mode && (captured_next != crc_next);
    end
  end

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop && head_entry.last |=> result_valid)
    else $error("record end did not load a result beat");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    pop && head_entry.last |=> (crc == crcsk_pkg::CRC_START) && (captured == '0))
    else $error("record state not restarted after last byte");

  a_inner_never_blocked: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head_entry.last |-> pop)
    else $error("non-final byte held in queue");

endmodule

`default_nettype wire

// File: rtl/crc32_record_check_with_skips_unit.sv
// ----------------------------------------------------------------------------
// crc32_record_check_with_skips_unit
// record crc-32 (poly 04c11db7, msb first) with result word and skip areas
// ----------------------------------------------------------------------------
// throughput: one item per cycle while the queue is not full
// skip compares, crc step combinational; result beat registered as last byte pops
// the two-entry queue lets items enter while a result beat waits on stall
// reset (synchronous): config cleared, crc 987654, position and skip count zero
// skip area entries are not cleared; only counted entries are ever compared
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_record_check_with_skips_unit #(
  parameter int MAX_SKIP_AREAS = crcsk_pkg::MAX_SKIP_AREAS,
  parameter int OFFSET_BITS    = crcsk_pkg::OFFSET_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [crcsk_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [crcsk_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic [1:0]                        func,
  input  wire logic [7:0]                        data_byte,
  input  wire logic [crcsk_pkg::FIELD_W-1:0]     area_offset,
  input  wire logic [crcsk_pkg::FIELD_W-1:0]     area_size,
  input  wire logic                              last_byte,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic [31:0]                            crc_value,
  output logic                                   mismatch
);

  localparam int AW = OFFSET_BITS;
  localparam int DW = crcsk_pkg::CFG_DATA_W;

  logic                  check_mode;
  logic                  result_present;
  logic [AW-1:0]         result_offset;
  logic [DW+AW-1:0]      cfg_ext;

  logic                  push;
  crcsk_pkg::entry_t     push_entry;
  logic                  queue_full;
  logic                  pop;
  logic                  head_valid;
  crcsk_pkg::entry_t     head_entry;

  assign cfg_ready = 1'b1;
  assign cfg_ext   = {{AW{1'b0}}, cfg_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode     <= 1'b0;
      result_present <= 1'b0;
      result_offset  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        crcsk_pkg::CFG_CHECK_MODE:     check_mode     <= cfg_data[0];
        crcsk_pkg::CFG_RESULT_PRESENT: result_present <= cfg_data[0];
        crcsk_pkg::CFG_RESULT_OFFSET:  result_offset  <= cfg_ext[AW-1:0];
        default: begin
        end
      endcase
    end
  end

  crcsk_front #(
    .MAX_SKIP_AREAS (MAX_SKIP_AREAS),
    .OFFSET_BITS    (OFFSET_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .func           (func),
    .data_byte      (data_byte),
    .area_offset    (area_offset),
    .area_size      (area_size),
    .last_byte      (last_byte),
    .result_present (result_present),
    .result_offset  (result_offset),
    .push           (push),
    .push_entry     (push_entry),
    .queue_full     (queue_full)
  );

  crcsk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  crcsk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .check_mode   (check_mode),
    .head_valid   (head_valid),
    .head_entry   (head_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .crc_value    (crc_value),
    .mismatch     (mismatch)
  );

endmodule

`default_nettype wire
